// ----- rtl/core/mpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpa_pkg;

    // sizing of the line store and the samples
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_WINDOW  = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int SIZE_W  = 9;
    localparam int WIN_W   = 4;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 3;

    // restoring remainder for the stride check, one dividend bit per cycle
    localparam int DIV_STEPS = COL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WIN_W-1:0]              arg_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic [CFG_W-1:0]              cfg_data_t;

    // register indexes
    localparam cfg_idx_t REG_IMAGE_WIDTH   = 3'd0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT  = 3'd1;
    localparam cfg_idx_t REG_WINDOW_WIDTH  = 3'd2;
    localparam cfg_idx_t REG_WINDOW_HEIGHT = 3'd3;
    localparam cfg_idx_t REG_STEP_ACROSS   = 3'd4;
    localparam cfg_idx_t REG_STEP_DOWN     = 3'd5;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 9'd8;
    localparam logic [WIN_W-1:0]  RST_WINDOW     = 4'd2;
    localparam logic [WIN_W-1:0]  RST_STEP       = 4'd2;

endpackage

`default_nettype wire

// ----- rtl/core/max_pool_2d_argmax_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2-D max pooling with argmax over signed Q8.8 samples given in raster
// order. The last eight rows (up to 256 columns each) live in a line store. A sample
// that cannot close a pooling window is only accepted; one that lies where a window
// could close is also put through the stride test, a restoring remainder that takes
// one column bit and one row bit per cycle, and s_ready stays low during the test.
// A sample that closes a window then holds s_ready low while the block scans the
// window: one line-store read per window entry through a single compare unit, a
// drain state for the registered read, and the load of the result register, which
// waits while an earlier result has not been taken. The result is held in an output
// register, so the next sample may be taken while the result still waits for
// m_ready. The line store has no reset; windows only read entries written earlier
// in the same plane. A window larger than the image or than eight, or a zero window
// or stride, gives no results.

module max_pool_2d_argmax_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration writes
    input  wire logic               cfg_wr_en,
    input  wire mpa_pkg::cfg_idx_t  cfg_index,
    input  wire mpa_pkg::cfg_data_t cfg_data,
    // sample input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mpa_pkg::sample_t   s_sample_value,
    // window results
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mpa_pkg::sample_t        m_max_value,
    output mpa_pkg::arg_t           m_arg_col,
    output mpa_pkg::arg_t           m_arg_row,
    output logic                    m_plane_done
);

    import mpa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [SIZE_W-1:0] img_w_reg, img_h_reg;
    logic [WIN_W-1:0]  win_w_reg, win_h_reg, step_x_reg, step_y_reg;

    // raster position of the next sample
    logic [COL_W-1:0]  col_pos_reg, col_pos_next;
    logic [COL_W-1:0]  row_pos_reg, row_pos_next;

    // stride test
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [COL_W-1:0]     col_quo_reg, col_quo_next;
    logic [COL_W-1:0]     row_quo_reg, row_quo_next;
    logic [WIN_W-1:0]     col_rem_reg, col_rem_next;
    logic [WIN_W-1:0]     row_rem_reg, row_rem_next;

    // window geometry
    logic [COL_W-1:0]  left_reg, left_next;
    logic [SLOT_W-1:0] top_reg, top_next;
    logic              last_reg, last_next;

    // scan counters and compare stage
    logic [SLOT_W-1:0] kx_reg, kx_next, ky_reg, ky_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0] rd_kx_reg, rd_kx_next, rd_ky_reg, rd_ky_next;
    logic              first_reg, first_next;
    sample_t           best_reg, best_next;
    logic [SLOT_W-1:0] best_kx_reg, best_kx_next, best_ky_reg, best_ky_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    sample_t           m_max_value_reg;
    arg_t              m_arg_col_reg, m_arg_row_reg;
    logic              m_plane_done_reg;
    logic              out_load;

    // line store
    sample_t           line_mem [2**ADDR_W];
    sample_t           rd_data_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en;

    // effective sizes and window test
    logic [SIZE_W-1:0] img_w, img_h;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic [SIZE_W-1:0] col_org, row_org;
    logic              cfg_ok, candidate, last_win;

    // remainder step
    logic [WIN_W:0]    col_trial, row_trial;
    logic [WIN_W-1:0]  col_rem_step, row_rem_step;

    logic [SLOT_W-1:0] kw_m1, kh_m1;
    logic              s_fire;

    assign s_fire = s_valid && s_ready;

    // image size saturated to 1..MAX_WIDTH
    always_comb begin
        if (img_w_reg == '0) begin
            img_w = SIZE_W'(1);
        end else if (img_w_reg > SIZE_W'(MAX_WIDTH)) begin
            img_w = SIZE_W'(MAX_WIDTH);
        end else begin
            img_w = img_w_reg;
        end
        if (img_h_reg == '0) begin
            img_h = SIZE_W'(1);
        end else if (img_h_reg > SIZE_W'(MAX_WIDTH)) begin
            img_h = SIZE_W'(MAX_WIDTH);
        end else begin
            img_h = img_h_reg;
        end
    end

    // does the current sample sit at a window's bottom-right corner
    assign col_inc = {1'b0, col_pos_reg} + SIZE_W'(1);
    assign row_inc = {1'b0, row_pos_reg} + SIZE_W'(1);
    assign col_org = col_inc - SIZE_W'(win_w_reg);
    assign row_org = row_inc - SIZE_W'(win_h_reg);

    assign cfg_ok = (win_w_reg != '0) && (win_w_reg <= WIN_W'(MAX_WINDOW)) &&
                    (win_h_reg != '0) && (win_h_reg <= WIN_W'(MAX_WINDOW)) &&
                    (step_x_reg != '0) && (step_y_reg != '0) &&
                    (SIZE_W'(win_w_reg) <= img_w) && (SIZE_W'(win_h_reg) <= img_h);

    assign candidate = cfg_ok &&
                       ({1'b0, col_pos_reg} < img_w) && ({1'b0, row_pos_reg} < img_h) &&
                       (col_inc >= SIZE_W'(win_w_reg)) && (row_inc >= SIZE_W'(win_h_reg));

    assign last_win = (col_inc + SIZE_W'(step_x_reg) > img_w) &&
                      (row_inc + SIZE_W'(step_y_reg) > img_h);

    // one restoring remainder step per axis
    assign col_trial    = {col_rem_reg, col_quo_reg[COL_W-1]};
    assign row_trial    = {row_rem_reg, row_quo_reg[COL_W-1]};
    assign col_rem_step = (col_trial >= {1'b0, step_x_reg}) ?
                          WIN_W'(col_trial - {1'b0, step_x_reg}) : WIN_W'(col_trial);
    assign row_rem_step = (row_trial >= {1'b0, step_y_reg}) ?
                          WIN_W'(row_trial - {1'b0, step_y_reg}) : WIN_W'(row_trial);

    assign kw_m1 = SLOT_W'(win_w_reg - WIN_W'(1));
    assign kh_m1 = SLOT_W'(win_h_reg - WIN_W'(1));

    // line store ports
    assign wr_en   = s_fire;
    assign wr_addr = {row_pos_reg[SLOT_W-1:0], col_pos_reg};
    assign rd_addr = {SLOT_W'(top_reg + ky_reg), COL_W'(left_reg + COL_W'(kx_reg))};

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        div_cnt_next  = div_cnt_reg;
        col_quo_next  = col_quo_reg;
        row_quo_next  = row_quo_reg;
        col_rem_next  = col_rem_reg;
        row_rem_next  = row_rem_reg;
        left_next     = left_reg;
        top_next      = top_reg;
        last_next     = last_reg;
        kx_next       = kx_reg;
        ky_next       = ky_reg;
        rd_valid_next = 1'b0;
        rd_kx_next    = kx_reg;
        rd_ky_next    = ky_reg;
        first_next    = first_reg;
        best_next     = best_reg;
        best_kx_next  = best_kx_reg;
        best_ky_next  = best_ky_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // compare stage on the registered store data
        if (rd_valid_reg) begin
            first_next = 1'b0;
            if (first_reg || (rd_data_reg > best_reg)) begin
                best_next    = rd_data_reg;
                best_kx_next = rd_kx_reg;
                best_ky_next = rd_ky_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // advance the raster position
                    if (col_inc >= img_w) begin
                        col_pos_next = '0;
                        if (row_inc >= img_h) begin
                            row_pos_next = '0;
                        end else begin
                            row_pos_next = COL_W'(row_inc);
                        end
                    end else begin
                        col_pos_next = COL_W'(col_inc);
                    end
                    col_quo_next = COL_W'(col_org);
                    row_quo_next = COL_W'(row_org);
                    col_rem_next = '0;
                    row_rem_next = '0;
                    div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                    left_next    = COL_W'(col_org);
                    top_next     = SLOT_W'(row_org);
                    last_next    = last_win;
                    if (candidate) begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                col_rem_next = col_rem_step;
                row_rem_next = row_rem_step;
                col_quo_next = {col_quo_reg[COL_W-2:0], 1'b0};
                row_quo_next = {row_quo_reg[COL_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0) begin
                    if ((col_rem_step == '0) && (row_rem_step == '0)) begin
                        kx_next    = '0;
                        ky_next    = '0;
                        first_next = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                // one store read per cycle, raster order inside the window
                rd_valid_next = 1'b1;
                if (kx_reg == kw_m1) begin
                    kx_next = '0;
                    if (ky_reg == kh_m1) begin
                        state_next = ST_DRAIN;
                    end else begin
                        ky_next = ky_reg + SLOT_W'(1);
                    end
                end else begin
                    kx_next = kx_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            img_w_reg    <= RST_IMAGE_SIZE;
            img_h_reg    <= RST_IMAGE_SIZE;
            win_w_reg    <= RST_WINDOW;
            win_h_reg    <= RST_WINDOW;
            step_x_reg   <= RST_STEP;
            step_y_reg   <= RST_STEP;
        end else begin
            state_reg    <= state_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:   img_w_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT:  img_h_reg  <= cfg_data;
                    REG_WINDOW_WIDTH:  win_w_reg  <= cfg_data[WIN_W-1:0];
                    REG_WINDOW_HEIGHT: win_h_reg  <= cfg_data[WIN_W-1:0];
                    REG_STEP_ACROSS:   step_x_reg <= cfg_data[WIN_W-1:0];
                    REG_STEP_DOWN:     step_y_reg <= cfg_data[WIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        div_cnt_reg <= div_cnt_next;
        col_quo_reg <= col_quo_next;
        row_quo_reg <= row_quo_next;
        col_rem_reg <= col_rem_next;
        row_rem_reg <= row_rem_next;
        left_reg    <= left_next;
        top_reg     <= top_next;
        last_reg    <= last_next;
        kx_reg      <= kx_next;
        ky_reg      <= ky_next;
        rd_kx_reg   <= rd_kx_next;
        rd_ky_reg   <= rd_ky_next;
        first_reg   <= first_next;
        best_reg    <= best_next;
        best_kx_reg <= best_kx_next;
        best_ky_reg <= best_ky_next;
        if (out_load) begin
            m_max_value_reg  <= best_reg;
            m_arg_col_reg    <= WIN_W'(best_kx_reg) + WIN_W'(1);
            m_arg_row_reg    <= WIN_W'(best_ky_reg) + WIN_W'(1);
            m_plane_done_reg <= last_reg;
        end
    end

    // line store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= s_sample_value;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_max_value  = m_max_value_reg;
    assign m_arg_col    = m_arg_col_reg;
    assign m_arg_row    = m_arg_row_reg;
    assign m_plane_done = m_plane_done_reg;

endmodule

`default_nettype wire
